// ----- rtl/core/frame_deframer_sum7_check_defines.svh -----
// Assertion macros for the frame deframer core.
// Depends on nothing; assertion bodies expect clk and arst_n in scope.
`ifndef FRAME_DEFRAMER_SUM7_CHECK_DEFINES_SVH
`define FRAME_DEFRAMER_SUM7_CHECK_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define FDSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold.
`define FDSC_ASSERT_NEVER(label, cond, msg) \
	`FDSC_ASSERT(label, !(cond), msg)

`else

`define FDSC_ASSERT(label, prop, msg)
`define FDSC_ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ----- rtl/core/fdsc_pkg.sv -----
// Shared constants for the frame deframer core: status codes, register
// indexes and field widths. Depends on nothing.
package fdsc_pkg;

	localparam int BYTE_W   = 8;
	localparam int SUM_W    = 7;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 3;
	localparam int TDATA_W  = 48;

	// offset of the first byte past the header
	localparam logic [POS_W-1:0] FIRST_PAYLOAD_POS = 3'd7;

	localparam logic [1:0] CFG_HEAD    = 2'd0;
	localparam logic [1:0] CFG_TAIL    = 2'd1;
	localparam logic [1:0] CFG_MACHINE = 2'd2;
	localparam logic [1:0] CFG_UNIT    = 2'd3;

	localparam logic [2:0] POS_MACHINE  = 3'd1;
	localparam logic [2:0] POS_KIND     = 3'd2;
	localparam logic [2:0] POS_SENDER   = 3'd4;
	localparam logic [2:0] POS_RECEIVER = 3'd5;
	localparam logic [2:0] POS_COMMAND  = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MACHINE  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RECEIVER = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd4;
	localparam logic [STATUS_W-1:0] ST_ABORTED  = 3'd5;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	typedef struct packed {
		logic [STATUS_W-1:0] frame_status;
		logic [BYTE_W-1:0]   payload_count;
		logic [BYTE_W-1:0]   command_code;
		logic [BYTE_W-1:0]   sender_code;
		logic [BYTE_W-1:0]   frame_kind;
		logic [BYTE_W-1:0]   payload_byte;
	} rec_fields_t;

endpackage

// ----- rtl/core/frame_deframer_sum7_check.sv -----
// Frame deframer with 7-bit additive checksum: top level, single module.
// Depends on fdsc_pkg and frame_deframer_sum7_check_defines.svh.
//
// Channel   Dir  Payload                                          Handshake
// s_*       in   s_tdata[7:0]  rx_byte                            tvalid/tready
// m_*       out  m_tuser record_kind, m_tdata fields below       tvalid/tready
// cfg_*     in   cfg_index selects register, cfg_data value       cfg_we, no wait
//
// One byte per cycle sustained while m_tready holds high. An accepted request is
// registered in stage 1 and then decoded into the result register once stage 1
// is consumed; a payload byte leaves only once the next byte arrives.
// The single result register sets the rate: a stage-1 byte moves only when
// that register is empty or being drained this cycle.
// arst_n clears control, config and frame state; data registers are not reset.
// Back-pressure on m_tready stalls stage 1, and s_tready then drops.

`include "frame_deframer_sum7_check_defines.svh"

module frame_deframer_sum7_check
	import fdsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input byte stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
	// record stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [15:8] frame_kind,
	                                      // [23:16] sender_code, [31:24] command_code,
	                                      // [39:32] payload_count, [42:40] frame_status,
	                                      // [47:43] zero
	output logic               m_tuser,   // [0] record_kind
	// configuration writes
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [BYTE_W-1:0]  cfg_data
);

	// ---------------- configuration registers ----------------
	logic [BYTE_W-1:0] head_q, tail_q, machine_q, unit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			machine_q <= '0;
			unit_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEAD:    head_q    <= cfg_data;
				CFG_TAIL:    tail_q    <= cfg_data;
				CFG_MACHINE: machine_q <= cfg_data;
				CFG_UNIT:    unit_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: input register ----------------
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_vld_q;
	logic              proc;      // stage-1 byte is consumed this cycle

	assign proc     = valid_s1 && (!out_vld_q || m_tready);
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// ---------------- frame state ----------------
	logic              open_q;
	logic [POS_W-1:0]  pos_q;      // offset in frame, saturates at first payload
	logic [SUM_W-1:0]  sum_q;
	logic [BYTE_W-1:0] held_q;
	logic              held_vld_q;
	logic [BYTE_W-1:0] cap_machine_q, cap_kind_q, cap_sender_q;
	logic [BYTE_W-1:0] cap_receiver_q, cap_command_q;
	logic [BYTE_W-1:0] count_q;

	logic              open_d;
	logic [POS_W-1:0]  pos_d;
	logic [SUM_W-1:0]  sum_d;
	logic [BYTE_W-1:0] held_d;
	logic              held_vld_d;
	logic [BYTE_W-1:0] cap_machine_d, cap_kind_d, cap_sender_d;
	logic [BYTE_W-1:0] cap_receiver_d, cap_command_d;
	logic [BYTE_W-1:0] count_d;

	logic              emit;
	logic              rec_kind;
	rec_fields_t       rec;
	logic [STATUS_W-1:0] tail_status;
	logic              is_head, is_tail;

	assign is_head = (byte_s1 == head_q);
	assign is_tail = (byte_s1 == tail_q);

	// First failing check wins; a checksum with bit 7 set never matches.
	always_comb begin
		if (!held_vld_q)
			tail_status = ST_SHORT;
		else if (cap_machine_q != machine_q)
			tail_status = ST_MACHINE;
		else if (cap_receiver_q != unit_q)
			tail_status = ST_RECEIVER;
		else if (held_q != {1'b0, sum_q})
			tail_status = ST_CHECKSUM;
		else
			tail_status = ST_OK;
	end

	always_comb begin
		open_d         = open_q;
		pos_d          = pos_q;
		sum_d          = sum_q;
		held_d         = held_q;
		held_vld_d     = held_vld_q;
		cap_machine_d  = cap_machine_q;
		cap_kind_d     = cap_kind_q;
		cap_sender_d   = cap_sender_q;
		cap_receiver_d = cap_receiver_q;
		cap_command_d  = cap_command_q;
		count_d        = count_q;
		emit           = 1'b0;
		rec_kind       = KIND_END;
		// end-record view of the current frame; payload records override
		rec.payload_byte  = '0;
		rec.frame_kind    = cap_kind_q;
		rec.sender_code   = cap_sender_q;
		rec.command_code  = cap_command_q;
		rec.payload_count = count_q;
		rec.frame_status  = ST_ABORTED;

		if (is_head) begin
			// head always reopens; an open frame is reported as aborted
			emit           = open_q;
			open_d         = 1'b1;
			pos_d          = 3'd1;
			sum_d          = byte_s1[SUM_W-1:0];
			held_d         = '0;
			held_vld_d     = 1'b0;
			cap_machine_d  = '0;
			cap_kind_d     = '0;
			cap_sender_d   = '0;
			cap_receiver_d = '0;
			cap_command_d  = '0;
			count_d        = '0;
		end else if (open_q) begin
			if (is_tail) begin
				emit             = 1'b1;
				rec.frame_status = tail_status;
				open_d           = 1'b0;
				pos_d            = '0;
				sum_d            = '0;
				held_d           = '0;
				held_vld_d       = 1'b0;
				cap_machine_d    = '0;
				cap_kind_d       = '0;
				cap_sender_d     = '0;
				cap_receiver_d   = '0;
				cap_command_d    = '0;
				count_d          = '0;
			end else begin
				if (pos_q < FIRST_PAYLOAD_POS) begin
					case (pos_q)
						POS_MACHINE:  cap_machine_d  = byte_s1;
						POS_KIND:     cap_kind_d     = byte_s1;
						POS_SENDER:   cap_sender_d   = byte_s1;
						POS_RECEIVER: cap_receiver_d = byte_s1;
						POS_COMMAND:  cap_command_d  = byte_s1;
						default: ;
					endcase
					sum_d = sum_q + byte_s1[SUM_W-1:0];
					pos_d = pos_q + 3'd1;
				end else begin
					// one-byte delay: previous byte goes out, this one is held
					if (held_vld_q) begin
						emit              = 1'b1;
						rec_kind          = KIND_PAYLOAD;
						rec.payload_byte  = held_q;
						rec.frame_kind    = '0;
						rec.sender_code   = '0;
						rec.command_code  = '0;
						rec.payload_count = '0;
						rec.frame_status  = ST_OK;
						sum_d             = sum_q + held_q[SUM_W-1:0];
						if (count_q != 8'hFF)
							count_d = count_q + 8'd1;
					end
					held_d     = byte_s1;
					held_vld_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q         <= 1'b0;
			pos_q          <= '0;
			sum_q          <= '0;
			held_q         <= '0;
			held_vld_q     <= 1'b0;
			cap_machine_q  <= '0;
			cap_kind_q     <= '0;
			cap_sender_q   <= '0;
			cap_receiver_q <= '0;
			cap_command_q  <= '0;
			count_q        <= '0;
		end else if (proc) begin
			open_q         <= open_d;
			pos_q          <= pos_d;
			sum_q          <= sum_d;
			held_q         <= held_d;
			held_vld_q     <= held_vld_d;
			cap_machine_q  <= cap_machine_d;
			cap_kind_q     <= cap_kind_d;
			cap_sender_q   <= cap_sender_d;
			cap_receiver_q <= cap_receiver_d;
			cap_command_q  <= cap_command_d;
			count_q        <= count_d;
		end
	end

	// ---------------- result register ----------------
	rec_fields_t rec_q;
	logic        kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (proc && emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			rec_q  <= rec;
			kind_q <= rec_kind;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {{(TDATA_W - $bits(rec_fields_t)){1'b0}}, rec_q};

	// ---------------- checks ----------------
	`FDSC_ASSERT(a_stall_only_on_full, !s_tready |-> (valid_s1 && out_vld_q && !m_tready), "s_tready low without a blocked result")
	`FDSC_ASSERT_NEVER(a_held_outside_frame, held_vld_q && !open_q, "held byte with no open frame")
	`FDSC_ASSERT(a_held_after_header, held_vld_q |-> (pos_q == FIRST_PAYLOAD_POS), "held byte before header complete")
	`FDSC_ASSERT(a_payload_rec_clean, (m_tvalid && m_tuser == KIND_PAYLOAD) |-> (m_tdata[TDATA_W-1:8] == '0), "payload record carries end-record fields")
	`FDSC_ASSERT_NEVER(a_status_range, m_tvalid && m_tuser == KIND_END && (m_tdata[42:40] == 3'd6 || m_tdata[42:40] == 3'd7), "undefined frame status")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for frame_deframer_sum7_check: byte frames are fed
// in through the input stream and every record is checked against a model.
// Depends on fdsc_pkg and the deframer RTL.
module testbench;
	import fdsc_pkg::*;

	// one record as seen on the output stream, unpacked into its fields
	typedef struct packed {
		logic                kind;
		logic [BYTE_W-1:0]   payload_byte;
		logic [BYTE_W-1:0]   frame_kind;
		logic [BYTE_W-1:0]   sender_code;
		logic [BYTE_W-1:0]   command_code;
		logic [BYTE_W-1:0]   payload_count;
		logic [STATUS_W-1:0] frame_status;
	} record_t;

	// ways a generated frame can be damaged
	typedef enum int {
		FLAW_NONE,
		FLAW_MACHINE,
		FLAW_RECEIVER,
		FLAW_SUM,
		FLAW_SUM7,
		FLAW_SHORT,
		FLAW_CUT
	} flaw_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [BYTE_W-1:0]  s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [BYTE_W-1:0]  cfg_data = '0;

	frame_deframer_sum7_check i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// bytes waiting to be offered, and records the model says must come out
	logic [7:0] rx_pending[$];
	record_t    expected_records[$];

	// append at the back of the pending-byte and expected-record queues
	function automatic void offer_byte(input logic [7:0] b);
		rx_pending.insert(rx_pending.size(), b);
	endfunction

	function automatic void expect_record(input record_t r);
		expected_records.insert(expected_records.size(), r);
	endfunction

	int   n_fail = 0;
	int   n_accepted = 0;
	logic idle_on = 1'b1;   // random idle bursts on both streams
	logic sink_hold = 1'b0; // long receiver hold-off
	int   src_gap = 0;
	int   sink_gap = 0;

	// shadow of the configuration registers
	logic [7:0] head_cfg = '0, tail_cfg = '0, machine_cfg = '0, unit_cfg = '0;

	// model copy of the frame state
	logic       fr_open;
	logic [7:0] fr_pos;
	logic [6:0] fr_sum;
	logic [7:0] fr_held;
	logic       fr_held_ok;
	logic [7:0] cap_machine, cap_kind, cap_sender, cap_receiver, cap_command;
	logic [7:0] pay_count;

	function automatic void reset_frame_state();
		fr_open = 1'b0;
		fr_pos = '0;
		fr_sum = '0;
		fr_held = '0;
		fr_held_ok = 1'b0;
		cap_machine = '0;
		cap_kind = '0;
		cap_sender = '0;
		cap_receiver = '0;
		cap_command = '0;
		pay_count = '0;
	endfunction

	initial reset_frame_state();

	function automatic record_t end_record_of(input logic [2:0] status);
		record_t r;
		r = '0;
		r.kind = KIND_END;
		r.frame_kind = cap_kind;
		r.sender_code = cap_sender;
		r.command_code = cap_command;
		r.payload_count = pay_count;
		r.frame_status = status;
		return r;
	endfunction

	// Advance the frame model by one accepted byte; queue the record it causes.
	function automatic void deframe_byte(input logic [7:0] b);
		record_t    r;
		logic [2:0] status;
		r = '0;
		// a head always wins, even when head and tail codes are equal
		if (b == head_cfg) begin
			if (fr_open)
				expect_record(end_record_of(ST_ABORTED));
			reset_frame_state();
			fr_open = 1'b1;
			fr_sum = b[6:0];
			fr_pos = 8'd1;
			return;
		end
		// bytes between frames are dropped silently
		if (!fr_open)
			return;
		if (b == tail_cfg) begin
			// first fault found decides the status
			if (!fr_held_ok)
				status = ST_SHORT;
			else if (cap_machine != machine_cfg)
				status = ST_MACHINE;
			else if (cap_receiver != unit_cfg)
				status = ST_RECEIVER;
			else if (fr_held != {1'b0, fr_sum})
				status = ST_CHECKSUM;
			else
				status = ST_OK;
			expect_record(end_record_of(status));
			reset_frame_state();
			return;
		end
		if (fr_pos < FIRST_PAYLOAD_POS) begin
			case (fr_pos)
				POS_MACHINE:  cap_machine = b;
				POS_KIND:     cap_kind = b;
				POS_SENDER:   cap_sender = b;
				POS_RECEIVER: cap_receiver = b;
				POS_COMMAND:  cap_command = b;
				default: ;
			endcase
			fr_sum = fr_sum + b[6:0];
		end else begin
			// payload goes out one byte late so the last one can be the checksum
			if (fr_held_ok) begin
				r.kind = KIND_PAYLOAD;
				r.payload_byte = fr_held;
				expect_record(r);
				fr_sum = fr_sum + fr_held[6:0];
				if (pay_count != 8'hff)
					pay_count = pay_count + 8'd1;
			end
			fr_held = b;
			fr_held_ok = 1'b1;
		end
		if (fr_pos != 8'hff)
			fr_pos = fr_pos + 8'd1;
	endfunction

	// random byte that neither opens nor closes a frame
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == head_cfg || b == tail_cfg);
		return b;
	endfunction

	// Queue one frame under the current codes, optionally damaged; returns its length.
	function automatic int queue_frame(input int n_pay, input flaw_t flaw);
		logic [7:0] bytes[$];
		logic [7:0] b;
		logic [6:0] sum;
		int         cut;
		bytes.insert(bytes.size(), head_cfg);
		sum = head_cfg[6:0];
		for (int i = 1; i <= 6; i++) begin
			b = body_byte();
			if (i == 1)
				b = (flaw == FLAW_MACHINE) ? machine_cfg ^ (8'h1 << $urandom_range(0, 7))
					: machine_cfg;
			if (i == 5)
				b = (flaw == FLAW_RECEIVER) ? unit_cfg ^ (8'h1 << $urandom_range(0, 7))
					: unit_cfg;
			sum = sum + b[6:0];
			bytes.insert(bytes.size(), b);
		end
		for (int i = 0; i < n_pay; i++) begin
			b = body_byte();
			sum = sum + b[6:0];
			bytes.insert(bytes.size(), b);
		end
		b = {1'b0, sum};
		if (flaw == FLAW_SUM)
			b = b ^ (8'h1 << $urandom_range(0, 7));
		if (flaw == FLAW_SUM7)
			b = b | 8'h80; // bit 7 set can never match a 7-bit sum
		bytes.insert(bytes.size(), b);
		if (flaw == FLAW_SHORT) begin
			cut = $urandom_range(1, 8);
			while (bytes.size() > cut)
				void'(bytes.pop_back());
		end
		if (flaw == FLAW_CUT) begin
			// no tail: the next head cuts this frame off
			cut = $urandom_range(1, bytes.size() - 1);
			while (bytes.size() > cut)
				void'(bytes.pop_back());
		end else
			bytes.insert(bytes.size(), tail_cfg);
		foreach (bytes[i])
			offer_byte(bytes[i]);
		return bytes.size();
	endfunction

	// Sender: offers the oldest pending byte, holds it until the request is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata);
				rx_pending.delete(0);
				n_accepted <= n_accepted + 1;
			end
			// a request still waiting keeps valid and data untouched
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					s_tvalid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (idle_on && rx_pending.size() != 0 && $urandom_range(0, 7) == 0) begin
					s_tvalid <= 1'b0;
					src_gap <= $urandom_range(0, 7);
				end else if (rx_pending.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= rx_pending[0];
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want, got);
		if (got !== want) begin
			$error("%s expected %0h actual %0h", name, want, got);
			n_fail++;
		end
	endfunction

	// Receiver: checks each taken record against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : sink
		record_t want;
		record_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.payload_byte = m_tdata[7:0];
				got.frame_kind = m_tdata[15:8];
				got.sender_code = m_tdata[23:16];
				got.command_code = m_tdata[31:24];
				got.payload_count = m_tdata[39:32];
				got.frame_status = m_tdata[42:40];
				if (expected_records.size() == 0) begin
					$error("unexpected record: kind %0d data %0h", m_tuser, m_tdata);
					n_fail++;
				end else begin
					want = expected_records[0];
					expected_records.delete(0);
					check_field("record_kind", want.kind, got.kind);
					check_field("payload_byte", want.payload_byte, got.payload_byte);
					check_field("frame_kind", want.frame_kind, got.frame_kind);
					check_field("sender_code", want.sender_code, got.sender_code);
					check_field("command_code", want.command_code, got.command_code);
					check_field("payload_count", want.payload_count, got.payload_count);
					check_field("frame_status", want.frame_status, got.frame_status);
				end
			end
			if (sink_hold || sink_gap != 0) begin
				m_tready <= 1'b0;
				if (sink_gap != 0)
					sink_gap <= sink_gap - 1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				sink_gap <= $urandom_range(0, 7);
			end else
				m_tready <= 1'b1;
		end
	end

	// Long receiver hold-off mid-run: the sender keeps going, so the block
	// fills up and must drop s_tready.
	initial begin
		while (n_accepted < 170)
			@(posedge clk);
		sink_hold <= 1'b1;
		repeat (120) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// Everything sent has been taken and answered; allow for the two-stage
	// pipe since a byte may produce no record.
	task automatic wait_idle();
		while (rx_pending.size() != 0 || s_tvalid || expected_records.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_regs(input logic [7:0] h, t, m, u);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HEAD;
		cfg_data <= h;
		head_cfg = h;
		@(posedge clk);
		cfg_index <= CFG_TAIL;
		cfg_data <= t;
		tail_cfg = t;
		@(posedge clk);
		cfg_index <= CFG_MACHINE;
		cfg_data <= m;
		machine_cfg = m;
		@(posedge clk);
		cfg_index <= CFG_UNIT;
		cfg_data <= u;
		unit_cfg = u;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One setting of the codes, then a random mix of frames and line noise.
	task automatic run_phase(input logic [7:0] h, t, m, u, input int quota,
			input logic with_long);
		int    n;
		int    sel;
		flaw_t flaw;
		n = 0;
		wait_idle();
		set_regs(h, t, m, u);
		// a frame long enough to saturate the payload count
		if (with_long)
			n += queue_frame(258, FLAW_NONE);
		while (n < quota) begin
			sel = $urandom_range(0, 15);
			case (sel)
				0, 1: begin
					repeat ($urandom_range(1, 3)) begin
						offer_byte(8'($urandom_range(0, 255)));
						n++;
					end
				end
				2: begin
					flaw = $urandom_range(0, 1) ? FLAW_SHORT : FLAW_CUT;
					n += queue_frame($urandom_range(0, 6), flaw);
				end
				3, 4: begin
					flaw = flaw_t'($urandom_range(FLAW_MACHINE, FLAW_SUM7));
					n += queue_frame($urandom_range(0, 8), flaw);
				end
				default: n += queue_frame($urandom_range(0, 12), FLAW_NONE);
			endcase
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset codes: head and tail both zero, so a zero byte only reopens
		offer_byte(8'hff); // outside a frame, dropped
		offer_byte(8'h00);
		offer_byte(8'h80);
		offer_byte(8'h00); // reopens: aborted record
		offer_byte(8'h7f);
		wait_idle();

		set_regs(8'h68, 8'h16, 8'ha5, 8'h3c);
		void'(queue_frame(1, FLAW_NONE));  // its head aborts the frame left open
		offer_byte(8'hff);                 // between frames
		offer_byte(8'h68);                 // head then tail: too short
		offer_byte(8'h16);
		void'(queue_frame(0, FLAW_SUM7));  // checksum byte with bit 7 set

		run_phase(8'h00, 8'hff, 8'h80, 8'h7f, 50, 1'b0);
		run_phase(8'h55, 8'haa, 8'h00, 8'hff, 50, 1'b0);
		run_phase(8'hff, 8'h00, 8'h5a, 8'h00, 50, 1'b0);
		run_phase(8'h7e, 8'h7e, 8'h33, 8'hc4, 30, 1'b0); // tail can never close
		run_phase(8'h10, 8'h20, 8'hff, 8'h11, 50, 1'b1);
		idle_on <= 1'b0;
		run_phase(8'hc0, 8'h3f, 8'h12, 8'he7, 50, 1'b0);
		wait_idle();
		repeat (10) @(posedge clk);

		if (n_fail == 0 && expected_records.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
